FILE: design/grb_pkg.sv
// Shared types, register offsets and helper functions of the GPIO register block.
`default_nettype none

package grb_pkg;

    localparam int PIN_COUNT = 54;
    localparam int FSEL_WORDS = 6;
    localparam int FSEL_PINS = 10;
    localparam int FSEL_BITS = 3 * FSEL_PINS;
    localparam int FSEL_MAX_PINS = FSEL_WORDS * FSEL_PINS;

    localparam int IN_TDATA_WIDTH = ((6 + 32 + PIN_COUNT + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH = ((32 + 4 * PIN_COUNT + 7) / 8) * 8;

    localparam logic [63:0] PIN_MASK64 =
        (PIN_COUNT >= 64) ? {64{1'b1}} : ((64'd1 << PIN_COUNT) - 64'd1);

    localparam logic [5:0] OFS_FSEL_FIRST = 6'd0;
    localparam logic [5:0] OFS_FSEL_LAST  = 6'(FSEL_WORDS - 1);
    localparam logic [5:0] OFS_SET_LO     = 6'd7;
    localparam logic [5:0] OFS_SET_HI     = 6'd8;
    localparam logic [5:0] OFS_CLR_LO     = 6'd10;
    localparam logic [5:0] OFS_CLR_HI     = 6'd11;
    localparam logic [5:0] OFS_LEV_LO     = 6'd13;
    localparam logic [5:0] OFS_LEV_HI     = 6'd14;
    localparam logic [5:0] OFS_PUD        = 6'd37;
    localparam logic [5:0] OFS_PUDCLK_LO  = 6'd38;
    localparam logic [5:0] OFS_PUDCLK_HI  = 6'd39;

    localparam logic [2:0] FSEL_OUTPUT = 3'd1;

    localparam logic [1:0] PULL_DOWN = 2'd1;
    localparam logic [1:0] PULL_UP   = 2'd2;

    typedef logic [PIN_COUNT-1:0] pin_vec_t;
    typedef logic [FSEL_WORDS-1:0][FSEL_BITS-1:0] fsel_words_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } grb_cmd_t;

    // Writable bits of one function-select word: three per existing pin.
    function automatic logic [FSEL_BITS-1:0] fsel_mask(input int word);
        logic [FSEL_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < FSEL_PINS; i++) begin
            if (word * FSEL_PINS + i < PIN_COUNT) begin
                m[3*i +: 3] = 3'b111;
            end
        end
        return m;
    endfunction

    // Output enable per pin: set where the function code selects output.
    function automatic pin_vec_t enables(input fsel_words_t fsel);
        pin_vec_t oe;
        oe = '0;
        for (int p = 0; p < PIN_COUNT; p++) begin
            if (p < FSEL_MAX_PINS) begin
                oe[p] = (fsel[p / FSEL_PINS][3 * (p % FSEL_PINS) +: 3] == FSEL_OUTPUT);
            end
        end
        return oe;
    endfunction

endpackage

`default_nettype wire

FILE: design/grb_ctrl.sv
// Controller state machine of the GPIO register block: beat handshakes and sequencing.
`default_nettype none

module grb_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output grb_pkg::grb_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.capture = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

FILE: design/grb_datapath.sv
// Datapath of the GPIO register block: register file, access decode and result register.
`default_nettype none

module grb_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire grb_pkg::grb_cmd_t                     cmd,
    input  wire logic                                  in_mode,
    input  wire logic [grb_pkg::IN_TDATA_WIDTH-1:0]    in_data,
    output logic [grb_pkg::OUT_TDATA_WIDTH-1:0]        out_data
);

    localparam int PC = grb_pkg::PIN_COUNT;

    logic                    wr_reg;
    logic [5:0]              ofs_reg;
    logic [31:0]             data_reg;
    grb_pkg::pin_vec_t       pads_reg;

    grb_pkg::fsel_words_t    fsel_reg;
    grb_pkg::fsel_words_t    fsel_next;
    grb_pkg::pin_vec_t       latch_reg;
    grb_pkg::pin_vec_t       latch_next;
    logic [1:0]              pud_ctl_reg;
    logic [1:0]              pud_ctl_next;
    logic [1:0][31:0]        pudclk_reg;
    logic [1:0][31:0]        pudclk_next;
    grb_pkg::pin_vec_t       pu_reg;
    grb_pkg::pin_vec_t       pu_next;
    grb_pkg::pin_vec_t       pd_reg;
    grb_pkg::pin_vec_t       pd_next;

    logic [grb_pkg::OUT_TDATA_WIDTH-1:0] out_reg;

    logic                    hi_half;
    logic [63:0]             sel64;
    grb_pkg::pin_vec_t       sel;
    grb_pkg::pin_vec_t       oe_now;
    grb_pkg::pin_vec_t       level;
    logic [63:0]             level64;
    logic [31:0]             rd;

    // The upper word of each set, clear and pull clock pair addresses pins 32 and up.
    assign hi_half = (ofs_reg == grb_pkg::OFS_SET_HI) || (ofs_reg == grb_pkg::OFS_CLR_HI)
        || (ofs_reg == grb_pkg::OFS_PUDCLK_HI);
    assign sel64 = (hi_half ? {data_reg, 32'd0} : {32'd0, data_reg}) & grb_pkg::PIN_MASK64;
    assign sel = sel64[PC-1:0];
    assign oe_now = grb_pkg::enables(fsel_reg);
    assign level = (latch_reg & oe_now) | (pads_reg & ~oe_now);
    assign level64 = 64'(level);

    always_comb
    begin
        fsel_next = fsel_reg;
        latch_next = latch_reg;
        pud_ctl_next = pud_ctl_reg;
        pudclk_next = pudclk_reg;
        pu_next = pu_reg;
        pd_next = pd_reg;
        rd = '0;
        unique case (ofs_reg) inside
            [grb_pkg::OFS_FSEL_FIRST:grb_pkg::OFS_FSEL_LAST]:
            begin
                if (wr_reg)
                begin
                    fsel_next[ofs_reg[2:0]] = data_reg[grb_pkg::FSEL_BITS-1:0]
                        & grb_pkg::fsel_mask(int'(ofs_reg));
                end
                else
                begin
                    rd = 32'(fsel_reg[ofs_reg[2:0]]);
                end
            end
            grb_pkg::OFS_SET_LO, grb_pkg::OFS_SET_HI:
            begin
                if (wr_reg)
                begin
                    latch_next = latch_reg | sel;
                end
            end
            grb_pkg::OFS_CLR_LO, grb_pkg::OFS_CLR_HI:
            begin
                if (wr_reg)
                begin
                    latch_next = latch_reg & ~sel;
                end
            end
            grb_pkg::OFS_LEV_LO, grb_pkg::OFS_LEV_HI:
            begin
                if (!wr_reg)
                begin
                    rd = (ofs_reg == grb_pkg::OFS_LEV_HI) ? level64[63:32] : level64[31:0];
                end
            end
            grb_pkg::OFS_PUD:
            begin
                if (wr_reg)
                begin
                    pud_ctl_next = data_reg[1:0];
                end
                else
                begin
                    rd = {30'd0, pud_ctl_reg};
                end
            end
            grb_pkg::OFS_PUDCLK_LO, grb_pkg::OFS_PUDCLK_HI:
            begin
                if (wr_reg)
                begin
                    pudclk_next[ofs_reg[0]] = ofs_reg[0] ? sel64[63:32] : sel64[31:0];
                    if (pud_ctl_reg == grb_pkg::PULL_DOWN)
                    begin
                        pd_next = pd_reg | sel;
                        pu_next = pu_reg & ~sel;
                    end
                    else if (pud_ctl_reg == grb_pkg::PULL_UP)
                    begin
                        pu_next = pu_reg | sel;
                        pd_next = pd_reg & ~sel;
                    end
                    else
                    begin
                        pu_next = pu_reg & ~sel;
                        pd_next = pd_reg & ~sel;
                    end
                end
                else
                begin
                    rd = pudclk_reg[ofs_reg[0]];
                end
            end
            default:
            begin
                rd = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            wr_reg <= in_mode;
            ofs_reg <= in_data[5:0];
            data_reg <= in_data[37:6];
            pads_reg <= in_data[38 +: PC];
        end
        if (cmd.commit)
        begin
            out_reg <= grb_pkg::OUT_TDATA_WIDTH'({pd_next, pu_next,
                grb_pkg::enables(fsel_next), latch_next, rd});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsel_reg <= '0;
            latch_reg <= '0;
            pud_ctl_reg <= '0;
            pudclk_reg <= '0;
            pu_reg <= '0;
            pd_reg <= '0;
        end
        else if (cmd.commit)
        begin
            fsel_reg <= fsel_next;
            latch_reg <= latch_next;
            pud_ctl_reg <= pud_ctl_next;
            pudclk_reg <= pudclk_next;
            pu_reg <= pu_next;
            pd_reg <= pd_next;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

FILE: design/gpio_register_block.sv
// Top level of the GPIO register block: controller, datapath and checks.
`default_nettype none

// Each input beat is one register access (tuser: 0 read, 1 write) with the sampled
// pad levels; each access yields exactly one output beat with the word read (zero for
// a write) and the pin outputs after the access. An access is captured from the beat in
// the idle state, then applied to the register file and loaded into the output register
// in the execute state once that register is empty or being read. Only one access is in
// flight; a finished result may wait in the output register while the next beat is
// captured.
module gpio_register_block (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // Fields from bit 0: word_offset, write_data, pad_levels, zero fill.
    input  wire logic [grb_pkg::IN_TDATA_WIDTH-1:0]    s_tdata,
    // Field: mode.
    input  wire logic                                  s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // Fields from bit 0: read_data, drive_levels, output_enables, pull_ups, pull_downs.
    output logic [grb_pkg::OUT_TDATA_WIDTH-1:0]        m_tdata
);

    localparam int PC = grb_pkg::PIN_COUNT;

    grb_pkg::grb_cmd_t cmd;

    grb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    grb_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_mode  (s_tuser),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

    // A captured beat closes the input until its result is committed.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an access is in flight");

    // A new result appears only after an access was captured.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result produced without a captured access");

    // A pin never has both pull resistors enabled.
    a_pull_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[32 + 2*PC +: PC] & m_tdata[32 + 3*PC +: PC]) == '0))
        else $error("pull-up and pull-down both enabled on a pin");

endmodule

`default_nettype wire

FILE: verif/grb_checker.sv
// Checker for the GPIO register block: predicts every result beat and compares it.
module grb_checker
    import grb_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    input  wire logic                       s_tready,
    input  wire logic [IN_TDATA_WIDTH-1:0]  s_tdata,
    input  wire logic                       s_tuser,
    input  wire logic                       m_tvalid,
    input  wire logic                       m_tready,
    input  wire logic [OUT_TDATA_WIDTH-1:0] m_tdata,
    output int                              errors,
    output int                              pending,
    output int                              checked
);

    typedef struct packed {
        logic [31:0] word;
        pin_vec_t    drive;
        pin_vec_t    oe;
        pin_vec_t    up;
        pin_vec_t    down;
    } pin_result_t;

    pin_result_t        result_q[$];
    logic [FSEL_BITS-1:0] fsel_reg [FSEL_WORDS];
    logic [63:0]        latch;
    logic [63:0]        up_res;
    logic [63:0]        down_res;
    logic [1:0]         pud_code;
    logic [31:0]        pudclk [2];

    function automatic logic [FSEL_BITS-1:0] fsel_keep(input int w);
        int live;
        live = PIN_COUNT - w * FSEL_PINS;
        if (live > FSEL_PINS)
            live = FSEL_PINS;
        if (live <= 0)
            return '0;
        return FSEL_BITS'((64'd1 << (3 * live)) - 64'd1);
    endfunction

    function automatic logic [63:0] pin_outputs();
        logic [63:0] o;
        logic [2:0]  code;
        o = '0;
        for (int p = 0; p < PIN_COUNT && p < FSEL_MAX_PINS; p++)
        begin
            code = fsel_reg[p / FSEL_PINS][3 * (p % FSEL_PINS) +: 3];
            o[p] = (code == FSEL_OUTPUT);
        end
        return o;
    endfunction

    function automatic logic [63:0] place_word(input logic [31:0] data, input logic hi);
        return hi ? {data, 32'd0} : {32'd0, data};
    endfunction

    task automatic predict_access(input logic wr, input logic [5:0] ofs,
                                  input logic [31:0] data, input logic [63:0] pads,
                                  output pin_result_t res);
        logic [63:0] oe;
        logic [63:0] lev;
        logic [63:0] sel;
        logic [31:0] word;
        logic        hi;
        word = '0;
        if (ofs <= OFS_FSEL_LAST)
        begin
            if (wr)
                fsel_reg[ofs[2:0]] = data[FSEL_BITS-1:0] & fsel_keep(int'(ofs));
            else
                word = 32'(fsel_reg[ofs[2:0]]);
        end
        else if (ofs == OFS_SET_LO || ofs == OFS_SET_HI)
        begin
            if (wr)
                latch = latch | (place_word(data, ofs == OFS_SET_HI) & PIN_MASK64);
        end
        else if (ofs == OFS_CLR_LO || ofs == OFS_CLR_HI)
        begin
            if (wr)
                latch = latch & ~(place_word(data, ofs == OFS_CLR_HI) & PIN_MASK64);
        end
        else if (ofs == OFS_LEV_LO || ofs == OFS_LEV_HI)
        begin
            if (!wr)
            begin
                oe = pin_outputs();
                lev = ((latch & oe) | (pads & ~oe)) & PIN_MASK64;
                word = (ofs == OFS_LEV_HI) ? lev[63:32] : lev[31:0];
            end
        end
        else if (ofs == OFS_PUD)
        begin
            if (wr)
                pud_code = data[1:0];
            else
                word = {30'd0, pud_code};
        end
        else if (ofs == OFS_PUDCLK_LO || ofs == OFS_PUDCLK_HI)
        begin
            hi = (ofs == OFS_PUDCLK_HI);
            if (wr)
            begin
                sel = place_word(data, hi) & PIN_MASK64;
                pudclk[hi] = hi ? sel[63:32] : sel[31:0];
                if (pud_code == PULL_DOWN)
                begin
                    down_res = down_res | sel;
                    up_res = up_res & ~sel;
                end
                else if (pud_code == PULL_UP)
                begin
                    up_res = up_res | sel;
                    down_res = down_res & ~sel;
                end
                else
                begin
                    up_res = up_res & ~sel;
                    down_res = down_res & ~sel;
                end
            end
            else
                word = pudclk[hi];
        end
        oe = pin_outputs();
        res.word = wr ? 32'd0 : word;
        res.drive = latch[PIN_COUNT-1:0];
        res.oe = oe[PIN_COUNT-1:0];
        res.up = up_res[PIN_COUNT-1:0];
        res.down = down_res[PIN_COUNT-1:0];
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pin_result_t res;
        pin_result_t want;
        if (!rst_n)
        begin
            for (int w = 0; w < FSEL_WORDS; w++)
                fsel_reg[w] = '0;
            latch = '0;
            up_res = '0;
            down_res = '0;
            pud_code = '0;
            pudclk[0] = '0;
            pudclk[1] = '0;
            result_q.delete();
            errors = 0;
            checked = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_access(s_tuser, s_tdata[5:0], s_tdata[37:6],
                               64'(s_tdata[38 +: PIN_COUNT]), res);
                result_q.push_back(res);
            end
            if (m_tvalid && m_tready)
            begin
                checked++;
                if (result_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with no access waiting, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("read_data", 64'(want.word), 64'(m_tdata[31:0]));
                    check_field("drive_levels", 64'(want.drive),
                                64'(m_tdata[32 +: PIN_COUNT]));
                    check_field("output_enables", 64'(want.oe),
                                64'(m_tdata[32 + PIN_COUNT +: PIN_COUNT]));
                    check_field("pull_ups", 64'(want.up),
                                64'(m_tdata[32 + 2 * PIN_COUNT +: PIN_COUNT]));
                    check_field("pull_downs", 64'(want.down),
                                64'(m_tdata[32 + 3 * PIN_COUNT +: PIN_COUNT]));
                end
            end
        end
        pending = result_q.size();
    end

endmodule

FILE: verif/tb_gpio_register_block.sv
// Testbench top for the GPIO register block: stimulus, output stalls and verdict.
module tb_gpio_register_block;
    import grb_pkg::*;

    localparam logic       ACC_READ        = 1'b0;
    localparam logic       ACC_WRITE       = 1'b1;
    localparam logic [1:0] PULL_NONE       = 2'd0;
    localparam int         RANDOM_ACCESSES = 650;
    localparam int         QUIET_TAIL      = 80;
    localparam int         HOLD_CYCLES     = 120;
    localparam int         HOLD_START      = 300;
    localparam int         STALL_LIMIT     = 2000;

    logic                       clk;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [IN_TDATA_WIDTH-1:0]  s_tdata;
    logic                       s_tuser;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [OUT_TDATA_WIDTH-1:0] m_tdata;

    int errors;
    int pending;
    int checked;
    int sent = 0;
    int writes_sent = 0;
    int stall_cycles = 0;
    bit quiet = 1'b0;
    bit sender_gaps = 1'b0;

    gpio_register_block DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    grb_checker u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [PIN_COUNT-1:0] any_pads();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[PIN_COUNT-1:0];
    endfunction

    // Function-select word leaning toward output codes, with the unused top bits random.
    function automatic logic [31:0] fsel_pattern();
        logic [31:0] d;
        d = $urandom;
        for (int i = 0; i < FSEL_PINS; i++)
        begin
            if ($urandom_range(0, 2) != 0)
                d[3 * i +: 3] = FSEL_OUTPUT;
        end
        return d;
    endfunction

    function automatic logic [5:0] pick_offset();
        logic [5:0] ofs;
        if ($urandom_range(0, 99) < 20)
            return 6'($urandom_range(0, 63));
        case ($urandom_range(0, 5))
            0: ofs = OFS_FSEL_FIRST + 6'($urandom_range(0, FSEL_WORDS - 1));
            1: ofs = $urandom_range(0, 1) ? OFS_SET_HI : OFS_SET_LO;
            2: ofs = $urandom_range(0, 1) ? OFS_CLR_HI : OFS_CLR_LO;
            3: ofs = $urandom_range(0, 1) ? OFS_LEV_HI : OFS_LEV_LO;
            4: ofs = OFS_PUD;
            default: ofs = $urandom_range(0, 1) ? OFS_PUDCLK_HI : OFS_PUDCLK_LO;
        endcase
        return ofs;
    endfunction

    task automatic send_access(input logic wr, input logic [5:0] ofs,
                               input logic [31:0] data, input logic [PIN_COUNT-1:0] pads);
        int gap;
        gap = 0;
        if (sender_gaps && !quiet && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 17);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser = wr;
        s_tdata = IN_TDATA_WIDTH'({pads, data, ofs});
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
        if (wr)
            writes_sent++;
    endtask

    task automatic pull_sequence();
        logic [5:0] clk_ofs;
        clk_ofs = $urandom_range(0, 1) ? OFS_PUDCLK_HI : OFS_PUDCLK_LO;
        send_access(ACC_WRITE, OFS_PUD, $urandom, any_pads());
        send_access(ACC_WRITE, clk_ofs, $urandom, any_pads());
        send_access(ACC_READ, clk_ofs, $urandom, any_pads());
        send_access(ACC_READ, OFS_PUD, $urandom, any_pads());
    endtask

    task automatic output_sequence();
        send_access(ACC_WRITE, OFS_FSEL_FIRST + 6'($urandom_range(0, FSEL_WORDS - 1)),
                    fsel_pattern(), any_pads());
        send_access(ACC_WRITE, $urandom_range(0, 1) ? OFS_SET_HI : OFS_SET_LO,
                    $urandom, any_pads());
        send_access(ACC_WRITE, $urandom_range(0, 1) ? OFS_CLR_HI : OFS_CLR_LO,
                    $urandom & $urandom, any_pads());
        send_access(ACC_READ, OFS_LEV_LO, $urandom, any_pads());
        send_access(ACC_READ, OFS_LEV_HI, $urandom, any_pads());
    endtask

    initial
    begin
        int total;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        send_access(ACC_READ, OFS_FSEL_FIRST, 32'd0, '0);
        send_access(ACC_READ, OFS_LEV_LO, 32'd0, '1);
        send_access(ACC_READ, OFS_LEV_HI, 32'd0, '1);
        send_access(ACC_WRITE, OFS_FSEL_FIRST, 32'hFFFF_FFFF, '0);
        send_access(ACC_WRITE, OFS_FSEL_FIRST, 32'hC924_9249, '0);
        send_access(ACC_WRITE, OFS_FSEL_LAST, 32'hFFFF_F249, '0);
        send_access(ACC_READ, OFS_FSEL_LAST, 32'd0, '0);
        send_access(ACC_WRITE, OFS_SET_LO, 32'hFFFF_FFFF, '0);
        send_access(ACC_WRITE, OFS_SET_HI, 32'hFFFF_FFFF, '0);
        send_access(ACC_READ, OFS_SET_LO, 32'd0, '0);
        send_access(ACC_READ, OFS_LEV_LO, 32'd0, '0);
        send_access(ACC_READ, OFS_LEV_HI, 32'd0, '1);
        send_access(ACC_WRITE, OFS_CLR_LO, 32'hAAAA_AAAA, '1);
        send_access(ACC_WRITE, OFS_CLR_HI, 32'hFFFF_FFFF, '0);
        send_access(ACC_WRITE, OFS_LEV_LO, 32'hFFFF_FFFF, '0);
        send_access(ACC_WRITE, OFS_PUD, 32'hFFFF_FFFF, '0);
        send_access(ACC_READ, OFS_PUD, 32'd0, '0);
        send_access(ACC_WRITE, OFS_PUDCLK_LO, 32'hFFFF_FFFF, '0);
        send_access(ACC_WRITE, OFS_PUD, 32'(PULL_UP), '0);
        send_access(ACC_WRITE, OFS_PUDCLK_HI, 32'hFFFF_FFFF, '0);
        send_access(ACC_READ, OFS_PUDCLK_HI, 32'd0, '0);
        send_access(ACC_WRITE, OFS_PUD, 32'(PULL_DOWN), '0);
        send_access(ACC_WRITE, OFS_PUDCLK_LO, 32'h0000_FFFF, '0);
        send_access(ACC_WRITE, OFS_PUD, 32'(PULL_NONE), '0);
        send_access(ACC_WRITE, 6'd63, 32'hFFFF_FFFF, '1);
        send_access(ACC_READ, 6'd63, 32'd0, '1);

        total = sent + RANDOM_ACCESSES;
        while (sent < total)
        begin
            int pick;
            quiet = (sent >= total - QUIET_TAIL);
            sender_gaps = ((sent / 60) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (pick < 15)
                pull_sequence();
            else if (pick < 35)
                output_sequence();
            else
                send_access(1'($urandom_range(0, 1)), pick_offset(), $urandom, any_pads());
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Run covered %0d accesses (%0d writes, %0d reads) and checked %0d result beats,",
                 sent, writes_sent, sent - writes_sent, checked);
        $display("including every register offset, back-to-back beats and long output stalls.");
        if (errors == 0 && pending == 0)
            $display("tb_gpio_register_block: PASS");
        else
            $display("tb_gpio_register_block: FAIL");
        $finish;
    end

    // Output side: random ready bursts, one long hold-off, and a steady tail.
    initial
    begin
        int  cycle;
        int  span;
        bit  held;
        bit  stall;
        cycle = 0;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (quiet)
            begin
                @(negedge clk);
                m_tready = 1'b1;
                cycle++;
            end
            else if (!held && cycle >= HOLD_START)
            begin
                held = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    m_tready = 1'b0;
                    cycle++;
                end
            end
            else
            begin
                stall = ((cycle / 200) % 3 != 2) && ($urandom_range(0, 2) == 0);
                span = stall ? $urandom_range(1, 17) : $urandom_range(1, 30);
                repeat (span)
                begin
                    @(negedge clk);
                    m_tready = !stall;
                    cycle++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
            $display("tb_gpio_register_block: FAIL");
            $finish;
        end
    end

endmodule
